@@ src/vsr_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared types, codes and constants of the voxel shape rasterizer
package vsr_pkg;

  localparam int FieldW      = 6;
  localparam int OpW         = 4;
  localparam int ChanW       = 8;
  localparam int RgbaW       = 4 * ChanW;
  localparam int CfgIdxW     = 4;
  localparam int GridDefault = 32;
  localparam int MulAW       = 2 * FieldW;

  localparam logic [ChanW-1:0] ColourReset = ChanW'(128);
  localparam logic [RgbaW-1:0] RgbaReset   = {4{ColourReset}};

  localparam logic StatusDone   = 1'b0;
  localparam logic StatusReject = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_PUT_VOXEL     = 4'd0,
    OP_CUT_VOXEL     = 4'd1,
    OP_PUT_BOX       = 4'd2,
    OP_CUT_BOX       = 4'd3,
    OP_PUT_SPHERE    = 4'd4,
    OP_CUT_SPHERE    = 4'd5,
    OP_PUT_ELLIPSOID = 4'd6,
    OP_CUT_ELLIPSOID = 4'd7,
    OP_READ          = 4'd8
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RED   = 4'd0,
    CFG_GREEN = 4'd1,
    CFG_BLUE  = 4'd2,
    CFG_ALPHA = 4'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_SETUP,
    ST_MULWAIT,
    ST_ROWSUM,
    ST_SWEEP,
    ST_ROWSTEP,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    SU_RX2,
    SU_RY2,
    SU_RZ2,
    SU_A,
    SU_B,
    SU_C,
    SU_L,
    SU_XK,
    SU_XF,
    SU_YK,
    SU_YF,
    SU_ZK,
    SU_ZF
  } setup_e;

  typedef struct packed {
    logic             on_we;
    logic             rgba_we;
    logic             on_bit;
    logic [RgbaW-1:0] rgba;
  } store_wr_t;

  typedef struct packed {
    logic             on_bit;
    logic [RgbaW-1:0] rgba;
  } store_rd_t;

endpackage

@@ src/vsr_if.sv @@
`timescale 1ns / 1ps
// Interfaces: command and response channels of the voxel shape rasterizer
interface vsr_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [vsr_pkg::OpW-1:0]      operation;
  logic [vsr_pkg::FieldW-1:0]   x_low;
  logic [vsr_pkg::FieldW-1:0]   y_low;
  logic [vsr_pkg::FieldW-1:0]   z_low;
  logic [vsr_pkg::FieldW-1:0]   x_high;
  logic [vsr_pkg::FieldW-1:0]   y_high;
  logic [vsr_pkg::FieldW-1:0]   z_high;
  logic [vsr_pkg::FieldW-1:0]   radius_x;
  logic [vsr_pkg::FieldW-1:0]   radius_y;
  logic [vsr_pkg::FieldW-1:0]   radius_z;

  modport source (
    output valid, operation, x_low, y_low, z_low, x_high, y_high, z_high,
           radius_x, radius_y, radius_z,
    input  ready
  );
  modport sink (
    input  valid, operation, x_low, y_low, z_low, x_high, y_high, z_high,
           radius_x, radius_y, radius_z,
    output ready
  );
endinterface

interface vsr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic                        voxel_on;
  logic [vsr_pkg::ChanW-1:0]   voxel_red;
  logic [vsr_pkg::ChanW-1:0]   voxel_green;
  logic [vsr_pkg::ChanW-1:0]   voxel_blue;
  logic [vsr_pkg::ChanW-1:0]   voxel_alpha;

  modport source (
    output valid, status, voxel_on, voxel_red, voxel_green, voxel_blue, voxel_alpha,
    input  ready
  );
  modport sink (
    input  valid, status, voxel_on, voxel_red, voxel_green, voxel_blue, voxel_alpha,
    output ready
  );
endinterface

@@ src/voxel_shape_rasterizer.sv @@
`timescale 1ns / 1ps
// Top level: voxel store with voxel, box, sphere and ellipsoid put and cut commands and reads
// Reset: a clearing pass writes all 2^AW store entries; no command is taken meanwhile, colour
// writes are. Voxel set and clear write the store in the check state. Read: the registered
// store data is captured in the read state. Box: per z row a row-sum step, a sweep writing
// one voxel at a time (single store write port), a row step. Sphere, ellipsoid: 13 products
// on the shared multiplier, a grid sweep. One command at a time, until its result is registered.
module voxel_shape_rasterizer #(
  parameter int GRID_X = vsr_pkg::GridDefault,
  parameter int GRID_Y = vsr_pkg::GridDefault,
  parameter int GRID_Z = vsr_pkg::GridDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  vsr_cmd_if.sink                      cmd_i,
  vsr_rsp_if.source                    rsp_o,
  input  logic                         cfg_we_i,
  input  logic [vsr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vsr_pkg::ChanW-1:0]    cfg_data_i
);

  localparam int AW = $clog2(GRID_X) + $clog2(GRID_Y) + $clog2(GRID_Z);

  logic [vsr_pkg::ChanW-1:0] red_q, green_q, blue_q, alpha_q;
  logic [AW-1:0]             st_addr;
  vsr_pkg::store_wr_t        st_wr;
  vsr_pkg::store_rd_t        st_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= vsr_pkg::ColourReset;
      green_q <= vsr_pkg::ColourReset;
      blue_q  <= vsr_pkg::ColourReset;
      alpha_q <= vsr_pkg::ColourReset;
    end else if (cfg_we_i) begin
      case (vsr_pkg::cfg_reg_e'(cfg_idx_i))
        vsr_pkg::CFG_RED:   red_q   <= cfg_data_i;
        vsr_pkg::CFG_GREEN: green_q <= cfg_data_i;
        vsr_pkg::CFG_BLUE:  blue_q  <= cfg_data_i;
        vsr_pkg::CFG_ALPHA: alpha_q <= cfg_data_i;
        default: begin
          red_q <= red_q;
        end
      endcase
    end
  end

  vsr_ctrl #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .rsp_o     (rsp_o),
    .colour_i  ({alpha_q, blue_q, green_q, red_q}),
    .st_addr_o (st_addr),
    .st_wr_o   (st_wr),
    .st_rd_i   (st_rd)
  );

  vsr_store #(
    .AW (AW)
  ) u_store (
    .clk_i  (clk_i),
    .addr_i (st_addr),
    .wr_i   (st_wr),
    .rd_o   (st_rd)
  );

endmodule

@@ src/vsr_mul.sv @@
`timescale 1ns / 1ps
// Shared shift-and-add multiplier, one multiplier bit per cycle
module vsr_mul #(
  parameter int PW = 39
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [vsr_pkg::MulAW-1:0] a_i,
  input  logic [PW-1:0]             b_i,
  output logic                      done_o,
  output logic [PW-1:0]             prod_o
);

  localparam int MAW  = vsr_pkg::MulAW;
  localparam int CntW = $clog2(MAW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [MAW-1:0]  a_q;
  logic [PW-1:0]   b_q;
  logic [PW-1:0]   acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(MAW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (a_q[0]) begin
        acc_q <= acc_q + b_q;
      end
      a_q <= a_q >> 1;
      b_q <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ src/vsr_store.sv @@
`timescale 1ns / 1ps
// Voxel store: on-bit memory and colour memory with a shared address
module vsr_store #(
  parameter int AW = 15
) (
  input  logic                clk_i,
  input  logic [AW-1:0]       addr_i,
  input  vsr_pkg::store_wr_t  wr_i,
  output vsr_pkg::store_rd_t  rd_o
);

  localparam int Depth = 1 << AW;

  logic                        on_mem   [Depth];
  logic [vsr_pkg::RgbaW-1:0]   rgba_mem [Depth];
  logic                        rd_on_q;
  logic [vsr_pkg::RgbaW-1:0]   rd_rgba_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.on_we) begin
      on_mem[addr_i] <= wr_i.on_bit;
    end
    rd_on_q <= on_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.rgba_we) begin
      rgba_mem[addr_i] <= wr_i.rgba;
    end
    rd_rgba_q <= rgba_mem[addr_i];
  end

  assign rd_o.on_bit = rd_on_q;
  assign rd_o.rgba   = rd_rgba_q;

endmodule

@@ src/vsr_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: clearing pass, command check, voxel read, shape setup on the shared multiplier, grid sweep
module vsr_ctrl #(
  parameter int GRID_X = vsr_pkg::GridDefault,
  parameter int GRID_Y = vsr_pkg::GridDefault,
  parameter int GRID_Z = vsr_pkg::GridDefault,
  localparam int XW = $clog2(GRID_X),
  localparam int YW = $clog2(GRID_Y),
  localparam int ZW = $clog2(GRID_Z),
  localparam int AW = XW + YW + ZW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  vsr_cmd_if.sink                    cmd_i,
  vsr_rsp_if.source                  rsp_o,
  input  logic [vsr_pkg::RgbaW-1:0]  colour_i,
  output logic [AW-1:0]              st_addr_o,
  output vsr_pkg::store_wr_t         st_wr_o,
  input  vsr_pkg::store_rd_t         st_rd_i
);

  localparam int FW  = vsr_pkg::FieldW;
  localparam int MAW = vsr_pkg::MulAW;
  localparam int CH  = vsr_pkg::ChanW;
  localparam int CWa = (XW > YW) ? XW : YW;
  localparam int CW  = (CWa > ZW) ? CWa : ZW;
  localparam int DW  = (CW > FW) ? CW : FW;
  localparam int VW  = 2 * DW + 4 * FW + 3;

  vsr_pkg::state_e state_q, state_d;
  vsr_pkg::setup_e step_q, step_d;
  logic [AW-1:0]   clr_q;
  logic            ov_q;

  vsr_pkg::op_e    op_q;
  logic [FW-1:0]   xl_q, yl_q, zl_q, xh_q, yh_q, zh_q, rx_q, ry_q, rz_q;

  logic [XW-1:0]   x_q, xlast_q;
  logic [YW-1:0]   y_q, ylo_q, ylast_q;
  logic [ZW-1:0]   z_q, zlo_q, zlast_q;

  logic [MAW-1:0]  rx2_q, ry2_q, rz2_q;
  logic signed [VW-1:0] ka_q, kb_q, kc_q, lim_q, fxy_q;
  logic signed [VW-1:0] fx_q, dx_q, fy_q, dy_q, fy0_q, dy0_q;
  logic signed [VW-1:0] fz_q, dz_q, fz0_q, dz0_q;
  logic signed [VW-1:0] sum_w;

  logic                        res_status_q, res_on_q;
  logic [vsr_pkg::RgbaW-1:0]   res_rgba_q;
  logic                        out_status_q, out_on_q;
  logic [vsr_pkg::RgbaW-1:0]   out_rgba_q;

  logic            in_grid, box_bad, box_empty, shape_bad, chk_reject;
  logic            is_box, is_voxel, on_val, paint, hit, out_free;
  logic            mul_start, mul_done;
  logic [MAW-1:0]  mul_a;
  logic [VW-1:0]   mul_b, mul_prod;

  vsr_mul #(
    .PW (VW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    in_grid   = (32'(xl_q) < GRID_X) && (32'(yl_q) < GRID_Y) && (32'(zl_q) < GRID_Z);
    box_bad   = (32'(xl_q) > GRID_X) || (32'(yl_q) > GRID_Y) || (32'(zl_q) > GRID_Z) ||
                (32'(xh_q) > GRID_X) || (32'(yh_q) > GRID_Y) || (32'(zh_q) > GRID_Z);
    box_empty = (xl_q >= xh_q) || (yl_q >= yh_q) || (zl_q >= zh_q);
    shape_bad = (rx_q == '0) || (ry_q == '0) || (rz_q == '0) ||
                (32'(xl_q) > GRID_X) || (32'(yl_q) > GRID_Y) || (32'(zl_q) > GRID_Z) ||
                (32'(xl_q) + 32'(rx_q) > GRID_X) || (32'(yl_q) + 32'(ry_q) > GRID_Y) ||
                (32'(zl_q) + 32'(rz_q) > GRID_Z);
    is_box    = (op_q == vsr_pkg::OP_PUT_BOX) || (op_q == vsr_pkg::OP_CUT_BOX);
    is_voxel  = (op_q == vsr_pkg::OP_PUT_VOXEL) || (op_q == vsr_pkg::OP_CUT_VOXEL);
    on_val    = (op_q == vsr_pkg::OP_PUT_VOXEL) || (op_q == vsr_pkg::OP_PUT_BOX) ||
                (op_q == vsr_pkg::OP_PUT_SPHERE) || (op_q == vsr_pkg::OP_PUT_ELLIPSOID);
    paint     = !((op_q == vsr_pkg::OP_CUT_VOXEL) || (op_q == vsr_pkg::OP_CUT_ELLIPSOID));
    sum_w     = fxy_q + fz_q;
    hit       = is_box || (sum_w <= lim_q);
    out_free  = !ov_q || rsp_o.ready;
    case (op_q)
      vsr_pkg::OP_PUT_VOXEL, vsr_pkg::OP_CUT_VOXEL, vsr_pkg::OP_READ: chk_reject = !in_grid;
      vsr_pkg::OP_PUT_BOX, vsr_pkg::OP_CUT_BOX: chk_reject = box_bad;
      vsr_pkg::OP_PUT_SPHERE, vsr_pkg::OP_CUT_SPHERE,
      vsr_pkg::OP_PUT_ELLIPSOID, vsr_pkg::OP_CUT_ELLIPSOID: chk_reject = shape_bad;
      default: chk_reject = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      vsr_pkg::ST_CLEAR: begin
        if (&clr_q) state_d = vsr_pkg::ST_IDLE;
      end
      vsr_pkg::ST_IDLE: begin
        if (cmd_i.valid) state_d = vsr_pkg::ST_CHECK;
      end
      vsr_pkg::ST_CHECK: begin
        step_d = vsr_pkg::SU_RX2;
        if (chk_reject || is_voxel) begin
          state_d = vsr_pkg::ST_DONE;
        end else if (op_q == vsr_pkg::OP_READ) begin
          state_d = vsr_pkg::ST_READ;
        end else if (is_box) begin
          state_d = box_empty ? vsr_pkg::ST_DONE : vsr_pkg::ST_ROWSUM;
        end else begin
          state_d = vsr_pkg::ST_SETUP;
        end
      end
      vsr_pkg::ST_READ:  state_d = vsr_pkg::ST_DONE;
      vsr_pkg::ST_SETUP: state_d = vsr_pkg::ST_MULWAIT;
      vsr_pkg::ST_MULWAIT: begin
        if (mul_done) begin
          if (step_q == vsr_pkg::SU_ZF) begin
            state_d = vsr_pkg::ST_ROWSUM;
          end else begin
            state_d = vsr_pkg::ST_SETUP;
            step_d  = vsr_pkg::setup_e'(step_q + 4'd1);
          end
        end
      end
      vsr_pkg::ST_ROWSUM: state_d = vsr_pkg::ST_SWEEP;
      vsr_pkg::ST_SWEEP: begin
        if (z_q == zlast_q) state_d = vsr_pkg::ST_ROWSTEP;
      end
      vsr_pkg::ST_ROWSTEP: begin
        state_d = ((y_q == ylast_q) && (x_q == xlast_q)) ? vsr_pkg::ST_DONE
                                                         : vsr_pkg::ST_ROWSUM;
      end
      vsr_pkg::ST_DONE: begin
        if (out_free) state_d = vsr_pkg::ST_IDLE;
      end
      default: state_d = vsr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_i.ready     = (state_q == vsr_pkg::ST_IDLE);
    mul_start       = (state_q == vsr_pkg::ST_SETUP);
    st_addr_o       = {x_q, y_q, z_q};
    st_wr_o.on_we   = 1'b0;
    st_wr_o.rgba_we = 1'b0;
    st_wr_o.on_bit  = on_val;
    st_wr_o.rgba    = colour_i;
    case (state_q)
      vsr_pkg::ST_CLEAR: begin
        st_addr_o       = clr_q;
        st_wr_o.on_we   = 1'b1;
        st_wr_o.rgba_we = 1'b1;
        st_wr_o.on_bit  = 1'b0;
        st_wr_o.rgba    = vsr_pkg::RgbaReset;
      end
      vsr_pkg::ST_CHECK: begin
        st_addr_o       = {XW'(xl_q), YW'(yl_q), ZW'(zl_q)};
        st_wr_o.on_we   = is_voxel && in_grid;
        st_wr_o.rgba_we = is_voxel && in_grid && paint;
      end
      vsr_pkg::ST_SWEEP: begin
        st_wr_o.on_we   = hit;
        st_wr_o.rgba_we = hit && paint;
      end
      default: begin
        st_wr_o.on_we   = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (step_q)
      vsr_pkg::SU_RX2: begin mul_a = MAW'(rx_q);  mul_b = VW'(rx_q);  end
      vsr_pkg::SU_RY2: begin mul_a = MAW'(ry_q);  mul_b = VW'(ry_q);  end
      vsr_pkg::SU_RZ2: begin mul_a = MAW'(rz_q);  mul_b = VW'(rz_q);  end
      vsr_pkg::SU_A:   begin mul_a = ry2_q;       mul_b = VW'(rz2_q); end
      vsr_pkg::SU_B:   begin mul_a = rx2_q;       mul_b = VW'(rz2_q); end
      vsr_pkg::SU_C:   begin mul_a = rx2_q;       mul_b = VW'(ry2_q); end
      vsr_pkg::SU_L:   begin mul_a = rx2_q;       mul_b = ka_q;       end
      vsr_pkg::SU_XK:  begin mul_a = MAW'(xl_q);  mul_b = ka_q;       end
      vsr_pkg::SU_XF:  begin mul_a = MAW'(xl_q);  mul_b = mul_prod;   end
      vsr_pkg::SU_YK:  begin mul_a = MAW'(yl_q);  mul_b = kb_q;       end
      vsr_pkg::SU_YF:  begin mul_a = MAW'(yl_q);  mul_b = mul_prod;   end
      vsr_pkg::SU_ZK:  begin mul_a = MAW'(zl_q);  mul_b = kc_q;       end
      vsr_pkg::SU_ZF:  begin mul_a = MAW'(zl_q);  mul_b = mul_prod;   end
      default:         begin mul_a = '0;          mul_b = '0;         end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsr_pkg::ST_CLEAR;
      step_q  <= vsr_pkg::SU_RX2;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == vsr_pkg::ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if ((state_q == vsr_pkg::ST_DONE) && out_free) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      vsr_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          op_q <= vsr_pkg::op_e'(cmd_i.operation);
          xl_q <= cmd_i.x_low;
          yl_q <= cmd_i.y_low;
          zl_q <= cmd_i.z_low;
          xh_q <= cmd_i.x_high;
          yh_q <= cmd_i.y_high;
          zh_q <= cmd_i.z_high;
          rx_q <= cmd_i.radius_x;
          if ((cmd_i.operation == vsr_pkg::OP_PUT_SPHERE) ||
              (cmd_i.operation == vsr_pkg::OP_CUT_SPHERE)) begin
            ry_q <= cmd_i.radius_x;
            rz_q <= cmd_i.radius_x;
          end else begin
            ry_q <= cmd_i.radius_y;
            rz_q <= cmd_i.radius_z;
          end
        end
      end
      vsr_pkg::ST_CHECK: begin
        res_status_q <= chk_reject ? vsr_pkg::StatusReject : vsr_pkg::StatusDone;
        res_on_q     <= 1'b0;
        res_rgba_q   <= '0;
        if (is_box) begin
          x_q     <= XW'(xl_q);
          y_q     <= YW'(yl_q);
          z_q     <= ZW'(zl_q);
          ylo_q   <= YW'(yl_q);
          zlo_q   <= ZW'(zl_q);
          xlast_q <= XW'(xh_q - FW'(1));
          ylast_q <= YW'(yh_q - FW'(1));
          zlast_q <= ZW'(zh_q - FW'(1));
        end else begin
          x_q     <= '0;
          y_q     <= '0;
          z_q     <= '0;
          ylo_q   <= '0;
          zlo_q   <= '0;
          xlast_q <= XW'(GRID_X - 1);
          ylast_q <= YW'(GRID_Y - 1);
          zlast_q <= ZW'(GRID_Z - 1);
        end
      end
      vsr_pkg::ST_READ: begin
        res_on_q   <= st_rd_i.on_bit;
        res_rgba_q <= st_rd_i.rgba;
      end
      vsr_pkg::ST_MULWAIT: begin
        if (mul_done) begin
          case (step_q)
            vsr_pkg::SU_RX2: rx2_q <= mul_prod[MAW-1:0];
            vsr_pkg::SU_RY2: ry2_q <= mul_prod[MAW-1:0];
            vsr_pkg::SU_RZ2: rz2_q <= mul_prod[MAW-1:0];
            vsr_pkg::SU_A:   ka_q  <= $signed(mul_prod);
            vsr_pkg::SU_B:   kb_q  <= $signed(mul_prod);
            vsr_pkg::SU_C:   kc_q  <= $signed(mul_prod);
            vsr_pkg::SU_L:   lim_q <= $signed(mul_prod);
            vsr_pkg::SU_XK:  dx_q  <= ka_q - $signed({mul_prod[VW-2:0], 1'b0});
            vsr_pkg::SU_XF:  fx_q  <= $signed(mul_prod);
            vsr_pkg::SU_YK: begin
              dy_q  <= kb_q - $signed({mul_prod[VW-2:0], 1'b0});
              dy0_q <= kb_q - $signed({mul_prod[VW-2:0], 1'b0});
            end
            vsr_pkg::SU_YF: begin
              fy_q  <= $signed(mul_prod);
              fy0_q <= $signed(mul_prod);
            end
            vsr_pkg::SU_ZK: begin
              dz_q  <= kc_q - $signed({mul_prod[VW-2:0], 1'b0});
              dz0_q <= kc_q - $signed({mul_prod[VW-2:0], 1'b0});
            end
            vsr_pkg::SU_ZF: begin
              fz_q  <= $signed(mul_prod);
              fz0_q <= $signed(mul_prod);
            end
            default: begin
              lim_q <= lim_q;
            end
          endcase
        end
      end
      vsr_pkg::ST_ROWSUM: begin
        fxy_q <= fx_q + fy_q;
      end
      vsr_pkg::ST_SWEEP: begin
        if (z_q != zlast_q) begin
          z_q  <= z_q + ZW'(1);
          fz_q <= fz_q + dz_q;
          dz_q <= dz_q + (kc_q <<< 1);
        end
      end
      vsr_pkg::ST_ROWSTEP: begin
        z_q  <= zlo_q;
        fz_q <= fz0_q;
        dz_q <= dz0_q;
        if (y_q != ylast_q) begin
          y_q  <= y_q + YW'(1);
          fy_q <= fy_q + dy_q;
          dy_q <= dy_q + (kb_q <<< 1);
        end else begin
          y_q  <= ylo_q;
          fy_q <= fy0_q;
          dy_q <= dy0_q;
          x_q  <= x_q + XW'(1);
          fx_q <= fx_q + dx_q;
          dx_q <= dx_q + (ka_q <<< 1);
        end
      end
      vsr_pkg::ST_DONE: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_on_q     <= res_on_q;
          out_rgba_q   <= res_rgba_q;
        end
      end
      default: begin
        fxy_q <= fxy_q;
      end
    endcase
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.voxel_on    = out_on_q;
  assign rsp_o.voxel_red   = out_rgba_q[CH-1:0];
  assign rsp_o.voxel_green = out_rgba_q[2*CH-1:CH];
  assign rsp_o.voxel_blue  = out_rgba_q[3*CH-1:2*CH];
  assign rsp_o.voxel_alpha = out_rgba_q[4*CH-1:3*CH];

endmodule
